@@ hw/rtl/stq_pkg.sv @@
// shared types and constants for the sorted timer queue
package stq_pkg;

    localparam logic [2:0] ACT_TICK    = 3'd0;
    localparam logic [2:0] ACT_START   = 3'd1;
    localparam logic [2:0] ACT_ABS     = 3'd2;
    localparam logic [2:0] ACT_STOP    = 3'd3;
    localparam logic [2:0] ACT_RESTART = 3'd4;
    localparam logic [2:0] ACT_QUERY   = 3'd5;

    localparam logic [30:0] LATE_MAX = 31'h7FFF_FFFF;
    localparam logic [7:0]  MARGIN_RESET = 8'd2;
    localparam int          MAX_FIRES = 16;

    typedef enum logic [2:0] {
        t_idle,
        t_remove,
        t_insert,
        t_check,
        t_emit
    } t_state;

    // operation broadcast to every cell in the same cycle
    typedef struct packed {
        logic        rem;
        logic        ins;
        logic [5:0]  slot;
        logic [31:0] alarm;
    } t_cell_op;

    function automatic logic lies_before(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] d;
        begin
            d = a - b;
            lies_before = d[31];
        end
    endfunction

endpackage

@@ hw/rtl/stq_cell.sv @@
// one queue position: holds an entry and shifts toward head or tail
module stq_cell
    import stq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cell_op    i_op,
    input  logic        i_prev_valid,
    input  logic        i_prev_before,
    input  logic [5:0]  i_prev_slot,
    input  logic [31:0] i_prev_alarm,
    input  logic        i_next_valid,
    input  logic [5:0]  i_next_slot,
    input  logic [31:0] i_next_alarm,
    input  logic        i_prev_hit,
    output logic        o_valid,
    output logic        o_before,
    output logic        o_hit,
    output logic [5:0]  o_slot,
    output logic [31:0] o_alarm
);

    logic        r_valid;
    logic [5:0]  r_slot;
    logic [31:0] r_alarm;
    logic        w_hit_here;
    logic        w_before;

    assign w_hit_here = r_valid && (r_slot == i_op.slot);
    assign o_hit      = i_prev_hit || w_hit_here;
    assign w_before   = r_valid && lies_before(r_alarm, i_op.alarm);
    // every entry up to here lies before the new alarm
    assign o_before   = i_prev_before && w_before;
    assign o_valid    = r_valid;
    assign o_slot     = r_slot;
    assign o_alarm    = r_alarm;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_op.rem && o_hit) begin
            // shift up from the neighbor behind
            r_valid <= i_next_valid;
            r_slot  <= i_next_slot;
            r_alarm <= i_next_alarm;
        end else if (i_op.ins && !o_before) begin
            if (i_prev_before) begin
                r_valid <= 1'b1;
                r_slot  <= i_op.slot;
                r_alarm <= i_op.alarm;
            end else begin
                r_valid <= i_prev_valid;
                r_slot  <= i_prev_slot;
                r_alarm <= i_prev_alarm;
            end
        end
    end

endmodule

@@ hw/rtl/sorted_timer_queue.sv @@
// top level of the sorted timer queue
// Items are handled one at a time in a chain of SLOTS cells whose shift is registered. A
// command passes through the remove, insert and result states before its result is
// offered, and the next item is taken only after that result is accepted. A tick checks
// the head; for each fired slot it steps through remove, re-insert, result and the next
// check, and a tick that fires nothing returns to idle after the check. Result stalls
// lengthen both ticks and commands.
// late_margin resets to 2.
module sorted_timer_queue
    import stq_pkg::*;
#(
    parameter int SLOTS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // action[2:0], slot[6:3], ticks[37:7], periodic[38], abs_time[70:39]
    input  logic [71:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // result_slot[3:0], fired[4], lateness[35:5], is_active[36], status[37]
    output logic [39:0] m_axis_tdata,
    output logic        m_axis_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data
);

    localparam int SW = $clog2(SLOTS) > 0 ? $clog2(SLOTS) : 1;

    t_state r_state, n_state;
    logic [7:0]  r_margin;
    logic [31:0] r_time;
    logic [2:0]  r_act;
    logic [3:0]  r_slot_in;
    logic [30:0] r_ticks;
    logic        r_per;
    logic [31:0] r_at;
    logic [4:0]  r_fires;
    logic        r_out_valid;
    logic [39:0] r_out_data;
    logic        r_out_last;
    logic [39:0] r_pend;
    logic [5:0]  r_hslot;
    logic [31:0] r_halarm;
    logic [30:0] r_period [SLOTS];
    logic        r_isper  [SLOTS];

    t_cell_op    w_op;
    logic        c_valid  [SLOTS+1];
    logic        c_before [SLOTS+1];
    logic        c_hit    [SLOTS+1];
    logic [5:0]  c_slot   [SLOTS+1];
    logic [31:0] c_alarm  [SLOTS+1];
    logic        w_full;
    logic        w_inrange;
    logic [SW-1:0] w_sidx;
    logic        w_due;
    logic [31:0] w_diff;
    logic [31:0] w_margin_alarm;

    assign c_valid[0]  = 1'b1;
    assign c_before[0] = 1'b1;
    assign c_hit[0]    = 1'b0;
    assign c_slot[0]   = '0;
    assign c_alarm[0]  = '0;

    genvar g;
    generate
        for (g = 0; g < SLOTS; g++) begin : g_cell
            logic        w_nv;
            logic [5:0]  w_ns;
            logic [31:0] w_na;
            if (g == SLOTS - 1) begin : g_end
                assign w_nv = 1'b0;
                assign w_ns = '0;
                assign w_na = '0;
            end else begin : g_mid
                assign w_nv = c_valid[g+2];
                assign w_ns = c_slot[g+2];
                assign w_na = c_alarm[g+2];
            end
            stq_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_op         (w_op),
                .i_prev_valid (c_valid[g]),
                .i_prev_before(c_before[g]),
                .i_prev_slot  (c_slot[g]),
                .i_prev_alarm (c_alarm[g]),
                .i_next_valid (w_nv),
                .i_next_slot  (w_ns),
                .i_next_alarm (w_na),
                .i_prev_hit   (c_hit[g]),
                .o_valid      (c_valid[g+1]),
                .o_before     (c_before[g+1]),
                .o_hit        (c_hit[g+1]),
                .o_slot       (c_slot[g+1]),
                .o_alarm      (c_alarm[g+1])
            );
        end
    endgenerate

    assign w_full    = c_valid[SLOTS];
    assign w_inrange = ({3'b000, r_slot_in} < 7'(SLOTS));
    assign w_sidx    = SW'(r_slot_in);
    assign w_margin_alarm = c_alarm[1] + {24'd0, r_margin};
    assign w_due     = c_valid[1] && lies_before(w_margin_alarm, r_time);
    assign w_diff    = r_time - c_alarm[1];

    assign s_axis_tready = (r_state == t_idle) && !r_out_valid;
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

    logic [31:0] w_ins_alarm;
    always_comb begin
        w_ins_alarm = r_time + {1'b0, r_ticks};
        case (r_act)
            ACT_ABS:     w_ins_alarm = r_at;
            ACT_RESTART: w_ins_alarm = r_time + {1'b0, r_period[w_sidx]};
            default:     w_ins_alarm = r_time + {1'b0, r_ticks};
        endcase
    end

    always_comb begin
        n_state   = r_state;
        w_op.rem  = 1'b0;
        w_op.ins  = 1'b0;
        w_op.slot = {2'b00, r_slot_in};
        w_op.alarm = w_ins_alarm;
        case (r_state)
            t_idle: begin
                if (s_axis_tvalid && s_axis_tready) begin
                    n_state = (s_axis_tdata[2:0] == ACT_TICK) ? t_check : t_remove;
                end
            end
            t_remove: begin
                if (r_act == ACT_TICK) begin
                    w_op.slot = r_hslot;
                    w_op.rem  = 1'b1;
                    n_state   = t_insert;
                end else begin
                    w_op.rem = w_inrange && (r_act == ACT_START || r_act == ACT_ABS ||
                               r_act == ACT_STOP || r_act == ACT_RESTART) &&
                               !(r_act == ACT_START && r_per && r_ticks == '0);
                    n_state  = t_insert;
                end
            end
            t_insert: begin
                if (r_act == ACT_TICK) begin
                    w_op.slot  = r_hslot;
                    w_op.alarm = r_halarm + {1'b0, r_period[SW'(r_hslot)]};
                    w_op.ins   = r_isper[SW'(r_hslot)] && !w_full;
                    n_state    = t_emit;
                end else begin
                    w_op.ins = w_inrange && !w_full &&
                               (r_act == ACT_ABS || r_act == ACT_RESTART ||
                                (r_act == ACT_START && !(r_per && r_ticks == '0)));
                    n_state  = t_emit;
                end
            end
            t_check: begin
                if (r_fires == 5'(MAX_FIRES) || !w_due) n_state = t_idle;
                else n_state = t_remove;
            end
            t_emit: begin
                if (!r_out_valid) n_state = (r_act == ACT_TICK) ? t_check : t_idle;
            end
            default: n_state = t_idle;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= t_idle;
            r_margin    <= MARGIN_RESET;
            r_time      <= '0;
            r_out_valid <= 1'b0;
            r_out_last  <= 1'b0;
            r_fires     <= '0;
            for (int k = 0; k < SLOTS; k++) begin
                r_period[k] <= '0;
                r_isper[k]  <= 1'b0;
            end
        end else begin
            r_state <= n_state;
            if (cfg_valid && cfg_ready) r_margin <= cfg_data;
            if (m_axis_tvalid && m_axis_tready) r_out_valid <= 1'b0;
            case (r_state)
                t_idle: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        r_act     <= s_axis_tdata[2:0];
                        r_slot_in <= s_axis_tdata[6:3];
                        r_ticks   <= s_axis_tdata[37:7];
                        r_per     <= s_axis_tdata[38];
                        r_at      <= s_axis_tdata[70:39];
                        r_fires   <= '0;
                        if (s_axis_tdata[2:0] == ACT_TICK) r_time <= r_time + 32'd1;
                    end
                end
                t_check: begin
                    r_hslot  <= c_slot[1];
                    r_halarm <= c_alarm[1];
                    if (w_due && r_fires != 5'(MAX_FIRES)) r_fires <= r_fires + 5'd1;
                    // a fired item waits in the hold slot until the next check decides whether it is the final one
                    if (r_fires != '0) begin
                        r_out_valid <= 1'b1;
                        r_out_last  <= !w_due || r_fires == 5'(MAX_FIRES);
                        r_out_data  <= r_pend;
                    end
                end
                t_insert: begin
                    if (r_act != ACT_TICK) begin
                        r_out_data <= {2'b00,
                                       w_inrange && r_act == ACT_START && r_per &&
                                           r_ticks == '0,
                                       w_inrange && r_act == ACT_QUERY && c_hit[SLOTS],
                                       31'd0, 1'b0, r_slot_in};
                        if (w_inrange && r_act == ACT_START &&
                            !(r_per && r_ticks == '0)) begin
                            r_period[w_sidx] <= r_ticks;
                            r_isper[w_sidx]  <= r_per;
                        end
                        if (w_inrange && r_act == ACT_ABS) begin
                            r_period[w_sidx] <= 31'(r_at - r_time);
                            r_isper[w_sidx]  <= 1'b0;
                        end
                    end
                end
                t_emit: begin
                    if (r_act != ACT_TICK && !r_out_valid) begin
                        r_out_valid <= 1'b1;
                        r_out_last  <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == t_check && w_due && r_fires != 5'(MAX_FIRES)) begin
            r_pend <= {2'b00, 1'b0, 1'b0,
                       (w_diff > {1'b0, LATE_MAX}) ? LATE_MAX : w_diff[30:0],
                       1'b1, c_slot[1][3:0]};
        end
    end

endmodule

@@ sim/tb_top.sv @@
// testbench for the sorted timer queue: directed table, random commands and ticks, scoreboard
module tb_top;
    import stq_pkg::*;

    localparam int NSLOT = 16;

    typedef struct packed {
        logic [3:0]  rslot;
        logic        fired;
        logic [30:0] late;
        logic        active;
        logic        status;
        logic        last;
    } t_res;

    typedef struct {
        logic [2:0]  action;
        logic [3:0]  slot;
        logic [30:0] ticks;
        logic        periodic;
        logic [31:0] alarm;
        logic        chk;
        t_res        want;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_data;

    sorted_timer_queue dut (.*);

    // predictor state
    logic [31:0] now_q;
    logic [3:0]  q_slot [NSLOT];
    logic [31:0] q_alarm [NSLOT];
    int          q_cnt;
    logic [30:0] per_q [NSLOT];
    logic        isper_q [NSLOT];
    logic [7:0]  margin_q;

    t_res        pending[$];
    int          errors;
    int          idle_cycles;
    logic        rx_hold;
    int          rx_gap;

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int slot_pos(logic [3:0] s);
        for (int i = 0; i < q_cnt; i++)
            if (q_slot[i] == s) return i;
        return -1;
    endfunction

    function automatic void take_out(logic [3:0] s);
        int p;
        p = slot_pos(s);
        if (p < 0) return;
        for (int i = p; i < q_cnt - 1; i++) begin
            q_slot[i] = q_slot[i+1];
            q_alarm[i] = q_alarm[i+1];
        end
        q_cnt--;
    endfunction

    function automatic void put_in(logic [3:0] s, logic [31:0] a);
        int p;
        logic [31:0] d;
        p = 0;
        if (q_cnt >= NSLOT) return;
        while (p < q_cnt) begin
            d = q_alarm[p] - a;
            if (!d[31]) break;
            p++;
        end
        for (int i = q_cnt; i > p; i--) begin
            q_slot[i] = q_slot[i-1];
            q_alarm[i] = q_alarm[i-1];
        end
        q_slot[p] = s;
        q_alarm[p] = a;
        q_cnt++;
    endfunction

    function automatic void clear_timers();
        now_q = 0;
        q_cnt = 0;
        margin_q = MARGIN_RESET;
        for (int i = 0; i < NSLOT; i++) begin
            per_q[i] = 0;
            isper_q[i] = 0;
        end
    endfunction

    // computes the results of one item and queues them
    function automatic void predict_timers(logic [2:0] act, logic [3:0] s, logic [30:0] tk,
                                           logic per, logic [31:0] at);
        t_res r;
        int n;
        logic [31:0] d, ha, late;
        logic [3:0] hs;
        r = '0;
        if (act == ACT_TICK) begin
            now_q = now_q + 1;
            n = 0;
            while (q_cnt > 0 && n < MAX_FIRES) begin
                d = q_alarm[0] + {24'd0, margin_q} - now_q;
                if (!d[31]) break;
                hs = q_slot[0];
                ha = q_alarm[0];
                late = now_q - ha;
                if (late > {1'b0, LATE_MAX}) late = {1'b0, LATE_MAX};
                take_out(hs);
                if (isper_q[hs]) put_in(hs, ha + {1'b0, per_q[hs]});
                r = '0;
                r.rslot = hs;
                r.fired = 1;
                r.late = late[30:0];
                pending.push_back(r);
                n++;
            end
            if (n > 0) pending[pending.size()-1].last = 1;
            return;
        end
        r.rslot = s;
        r.last = 1;
        case (act)
            ACT_START: begin
                if (tk == 0 && per) r.status = 1;
                else begin
                    take_out(s);
                    per_q[s] = tk;
                    isper_q[s] = per;
                    put_in(s, now_q + {1'b0, tk});
                end
            end
            ACT_ABS: begin
                take_out(s);
                d = at - now_q;
                per_q[s] = d[30:0];
                isper_q[s] = 0;
                put_in(s, at);
            end
            ACT_STOP: take_out(s);
            ACT_RESTART: begin
                take_out(s);
                put_in(s, now_q + {1'b0, per_q[s]});
            end
            ACT_QUERY: r.active = slot_pos(s) >= 0;
            default: ;
        endcase
        pending.push_back(r);
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_res got, exp_r;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.rslot = m_axis_tdata[3:0];
            got.fired = m_axis_tdata[4];
            got.late = m_axis_tdata[35:5];
            got.active = m_axis_tdata[36];
            got.status = m_axis_tdata[37];
            got.last = m_axis_tlast;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
            end else begin
                exp_r = pending.pop_front();
                if (got !== exp_r) begin
                    $display("%0t: mismatch expected %h actual %h", $time, exp_r, got);
                    errors++;
                end
            end
        end
    end

    // receiver stalls, mostly short and now and then long
    always @(posedge i_clk) begin
        if (!i_rst_n || rx_hold) begin
            m_axis_tready <= 0;
            if (!i_rst_n) rx_gap <= 0;
        end else if (rx_gap > 0) begin
            m_axis_tready <= 0;
            rx_gap <= rx_gap - 1;
        end else if ($urandom_range(0, 3) == 0) begin
            m_axis_tready <= 0;
            rx_gap <= ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
                                                    : $urandom_range(0, 2);
        end else m_axis_tready <= 1;
    end

    // watchdog on cycles with no accepted item
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready) || !i_rst_n)
            idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    task automatic send_item(logic [2:0] act, logic [3:0] s, logic [30:0] tk, logic per,
                             logic [31:0] at);
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
        repeat (gap) @(posedge i_clk);
        s_axis_tvalid <= 1;
        s_axis_tdata <= {1'b0, at, per, tk, s, act};
        do @(posedge i_clk); while (!s_axis_tready);
        predict_timers(act, s, tk, per, at);
        s_axis_tvalid <= 0;
    endtask

    task automatic drain_all();
        while (pending.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_margin(logic [7:0] v);
        drain_all();
        cfg_valid <= 1;
        cfg_data <= v;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 0;
        margin_q = v;
    endtask

    task automatic random_items(int cnt);
        logic [2:0] act;
        logic [31:0] at;
        int k;
        for (int i = 0; i < cnt; i++) begin
            k = $urandom_range(0, 99);
            act = k < 45 ? ACT_TICK : 3'($urandom_range(1, 7));
            at = $urandom_range(0, 3) == 0 ? $urandom : now_q + $urandom_range(0, 12);
            send_item(act, 4'($urandom),
                      $urandom_range(0, 4) == 0 ? 31'($urandom) : 31'($urandom_range(0, 9)),
                      1'($urandom), at);
        end
    endtask

    t_row rows[$];

    function automatic t_row mk(logic [2:0] a, logic [3:0] s, logic [30:0] t, logic p,
                                logic [31:0] at, logic c, t_res w);
        t_row r;
        r.action = a; r.slot = s; r.ticks = t; r.periodic = p; r.alarm = at;
        r.chk = c; r.want = w;
        return r;
    endfunction

    initial begin
        errors = 0;
        rx_hold = 0;
        i_rst_n = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = '0;
        cfg_valid = 0;
        cfg_data = '0;
        clear_timers();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed table; typed-in results checked against predictor output
        rows.push_back(mk(ACT_QUERY, 0, 0, 0, 0, 1, '{0, 0, 0, 0, 0, 1}));
        rows.push_back(mk(ACT_STOP, 15, 0, 0, 0, 1, '{15, 0, 0, 0, 0, 1}));
        rows.push_back(mk(ACT_START, 3, 0, 1, 0, 1, '{3, 0, 0, 0, 1, 1}));
        rows.push_back(mk(3'd6, 7, '1, 1, '1, 1, '{7, 0, 0, 0, 0, 1}));
        rows.push_back(mk(3'd7, 9, 0, 0, 0, 1, '{9, 0, 0, 0, 0, 1}));
        rows.push_back(mk(ACT_START, 1, 0, 0, 0, 0, '0));
        rows.push_back(mk(ACT_START, 2, 1, 1, 0, 0, '0));
        rows.push_back(mk(ACT_START, 15, 31'h7FFF_FFFF, 1, 0, 0, '0));
        rows.push_back(mk(ACT_ABS, 4, 0, 0, 32'd3, 0, '0));
        rows.push_back(mk(ACT_ABS, 5, 0, 1, 32'hFFFF_FFFF, 0, '0));
        rows.push_back(mk(ACT_RESTART, 6, 0, 0, 0, 0, '0));
        rows.push_back(mk(ACT_QUERY, 4, 0, 0, 0, 1, '{4, 0, 0, 1, 0, 1}));
        for (int i = 0; i < 8; i++) rows.push_back(mk(ACT_TICK, 0, 0, 0, 0, 0, '0));
        rows.push_back(mk(ACT_RESTART, 4, 0, 0, 0, 0, '0));
        rows.push_back(mk(ACT_STOP, 2, 0, 0, 0, 0, '0));
        rows.push_back(mk(ACT_ABS, 8, 0, 0, 32'h8000_0000, 0, '0));
        for (int i = 0; i < rows.size(); i++) begin
            send_item(rows[i].action, rows[i].slot, rows[i].ticks, rows[i].periodic,
                      rows[i].alarm);
            if (rows[i].chk && pending[pending.size()-1] !== rows[i].want) begin
                $display("%0t: table row %0d expected %h actual %h", $time, i,
                         rows[i].want, pending[pending.size()-1]);
                errors++;
            end
        end

        // all slots due at once: more than one pop per tick, periodic re-inserts
        write_margin(8'd0);
        for (int s = 0; s < NSLOT; s++) send_item(ACT_START, 4'(s), 31'd2, 1'(s & 1), 0);
        repeat (4) send_item(ACT_TICK, 0, 0, 0, 0);
        random_items(70);

        write_margin(8'd255);
        random_items(40);
        repeat (30) send_item(ACT_TICK, 0, 0, 0, 0);

        // long receiver hold while commands keep coming
        write_margin(8'd1);
        fork
            begin
                rx_hold = 1;
                repeat (400) @(posedge i_clk);
                rx_hold = 0;
            end
            random_items(40);
        join
        drain_all();
        write_margin(8'($urandom));
        random_items(50);
        write_margin(MARGIN_RESET);
        random_items(50);

        drain_all();
        if (errors == 0 && pending.size() == 0) $display("tb_top OK");
        else $display("tb_top NOT OK");
        $finish;
    end

endmodule
